// ===== rtl/ilp_pkg.sv =====
// Shared types, character codes and helpers for the integer literal parser.
`default_nettype none
package ilp_pkg;

   localparam logic [1:0] MODE_DEC = 2'd0;
   localparam logic [1:0] MODE_HEX = 2'd1;
   localparam logic [1:0] MODE_BIN = 2'd2;

   localparam logic [4:0] NO_DIGIT = 5'd16;
   localparam logic [2:0] COUNT_MAX = 3'd7;
   localparam logic [2:0] HEAD_DEPTH = 3'd6;

   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_QUOTE = "'";
   localparam logic [7:0] CH_BSLASH = "\\";
   localparam logic [7:0] CH_ZERO = "0";
   localparam logic [7:0] CH_LC_X = "x";
   localparam logic [7:0] CH_LC_B = "b";
   localparam logic [7:0] CH_LC_A = "a";
   localparam logic [7:0] CH_LC_T = "t";
   localparam logic [7:0] CH_LC_N = "n";
   localparam logic [7:0] CH_LC_R = "r";
   localparam logic [7:0] CH_LC_U = "u";
   localparam logic [7:0] CH_LC_E = "e";
   localparam logic [7:0] CH_LC_F = "f";
   localparam logic [7:0] CH_LC_L = "l";
   localparam logic [7:0] CH_LC_S = "s";

   localparam logic [7:0] ESC_BELL = 8'd7;
   localparam logic [7:0] ESC_BACKSPACE = 8'd8;
   localparam logic [7:0] ESC_TAB = 8'd9;
   localparam logic [7:0] ESC_NEWLINE = 8'd10;
   localparam logic [7:0] ESC_RETURN = 8'd13;

   typedef struct packed {
      logic [2:0]      count;
      logic [5:0][7:0] head;
      logic [1:0]      mode;
      logic            negative;
      logic            digit_err;
   } ilp_state_type;

   localparam ilp_state_type STATE_RESET = '{
      count: 3'd0, head: '0, mode: MODE_DEC, negative: 1'b0, digit_err: 1'b0
   };

   // digit value of a hex character, NO_DIGIT otherwise
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      v = NO_DIGIT;
      if (c >= "0" && c <= "9") v = 5'(c - "0");
      else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ilp_step.sv =====
// Per-character state update and end-of-literal classification.
`default_nettype none
module ilp_step
   import ilp_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  wire logic [7:0]            step_char,
   input  wire ilp_state_type         state_cur,
   input  wire logic [VALUE_BITS-1:0] acc_cur,
   output ilp_state_type              state_nxt,
   output logic [VALUE_BITS-1:0]      acc_nxt,
   output logic                       res_valid,
   output logic signed [63:0]         res_value
);

   logic [2:0]            pos;
   logic [4:0]            dig;
   logic [4:0]            radix;
   logic                  do_digit;
   logic [VALUE_BITS-1:0] acc_step;
   logic [VALUE_BITS-1:0] num_val;
   logic [5:0][7:0]       h;
   logic [4:0]            hx_hi;
   logic [4:0]            hx_lo;

   always_comb begin
      pos = state_cur.count;
      state_nxt = state_cur;
      acc_nxt = acc_cur;
      do_digit = 1'b0;

      if (pos < HEAD_DEPTH) state_nxt.head[pos] = step_char;

      dig = hex_val(step_char);
      case (state_cur.mode)
         MODE_HEX: begin
            radix = 5'd16;
            acc_step = {acc_cur[VALUE_BITS-5:0], dig[3:0]};
         end
         MODE_BIN: begin
            radix = 5'd2;
            acc_step = {acc_cur[VALUE_BITS-2:0], dig[0]};
         end
         default: begin
            // x*10 = x*8 + x*2
            radix = 5'd10;
            acc_step = {acc_cur[VALUE_BITS-4:0], 3'b000}
                     + {acc_cur[VALUE_BITS-2:0], 1'b0}
                     + VALUE_BITS'(dig);
         end
      endcase

      if (pos == 3'd0) begin
         if (step_char == CH_MINUS) state_nxt.negative = 1'b1;
         else do_digit = 1'b1;
      end else if (pos == 3'd1 && state_cur.head[0] == CH_ZERO
                   && (step_char == CH_LC_X || step_char == CH_LC_B)) begin
         state_nxt.mode = (step_char == CH_LC_X) ? MODE_HEX : MODE_BIN;
         acc_nxt = '0;
      end else begin
         do_digit = 1'b1;
      end

      if (do_digit) begin
         if (dig >= radix) state_nxt.digit_err = 1'b1;
         else acc_nxt = acc_step;
      end

      state_nxt.count = (pos == COUNT_MAX) ? COUNT_MAX : pos + 3'd1;

      // classification as if this character closes the literal (pos = len-1)
      h = state_nxt.head;
      hx_hi = hex_val(h[3]);
      hx_lo = hex_val(h[4]);
      num_val = state_cur.negative ? (VALUE_BITS'(0) - acc_nxt) : acc_nxt;
      res_valid = 1'b0;
      res_value = '0;
      if (pos == 3'd3 && h[0] == CH_LC_T && h[1] == CH_LC_R && h[2] == CH_LC_U
          && h[3] == CH_LC_E) begin
         res_valid = 1'b1;
         res_value = 64'd1;
      end else if (pos == 3'd4 && h[0] == CH_LC_F && h[1] == CH_LC_A
                   && h[2] == CH_LC_L && h[3] == CH_LC_S && h[4] == CH_LC_E) begin
         res_valid = 1'b1;
      end else if (pos == 3'd2 && h[0] == CH_QUOTE && h[1] != CH_BSLASH
                   && h[2] == CH_QUOTE) begin
         res_valid = 1'b1;
         res_value = 64'(h[1]);
      end else if (pos == 3'd3 && h[0] == CH_QUOTE && h[1] == CH_BSLASH
                   && h[3] == CH_QUOTE) begin
         res_valid = 1'b1;
         case (h[2])
            CH_LC_A: res_value = 64'(ESC_BELL);
            CH_LC_B: res_value = 64'(ESC_BACKSPACE);
            CH_LC_T: res_value = 64'(ESC_TAB);
            CH_LC_N: res_value = 64'(ESC_NEWLINE);
            CH_LC_R: res_value = 64'(ESC_RETURN);
            default: res_valid = 1'b0;
         endcase
      end else if (pos == 3'd5 && h[0] == CH_QUOTE && h[1] == CH_BSLASH
                   && h[2] == CH_LC_X && h[5] == CH_QUOTE) begin
         if (hx_hi != NO_DIGIT && hx_lo != NO_DIGIT) begin
            res_valid = 1'b1;
            res_value = 64'({hx_hi[3:0], hx_lo[3:0]});
         end
      end else if (!state_nxt.digit_err) begin
         res_valid = 1'b1;
         res_value = 64'(signed'(num_val));
      end
   end

endmodule
`default_nettype wire

// ===== rtl/integer_literal_parser.sv =====
// Top level of the integer literal parser: input stage, parse state, result register.
`default_nettype none
// channel   direction  ports                               item
// req       in         req_valid/req_stall, char, last     one literal character
// rsp       out        rsp_valid/rsp_stall, valid, value   one parsed literal
//
// One character per cycle while req_stall is low; after the last character is
// accepted, it passes the input register, then the result register, which
// drives rsp_valid.
// Synchronous active-high reset clears the pipeline and the parse state.
// rsp_stall holds the result register and, once the input stage is full,
// raises req_stall in the same cycle.
module integer_literal_parser
   import ilp_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_char_code,
   input  wire logic              req_last_char,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_is_valid,
   output logic signed [63:0]     rsp_result_value
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_char_ff;
   logic                  s1_last_ff;
   ilp_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_is_valid_ff;
   logic signed [63:0]    out_value_ff;

   ilp_state_type         state_nxt;
   logic [VALUE_BITS-1:0] acc_nxt;
   logic                  res_valid;
   logic signed [63:0]    res_value;
   logic                  advance;
   logic                  s1_load;
   logic                  fire;

   ilp_step #(
      .VALUE_BITS(VALUE_BITS)
   ) u_step (
      .step_char (s1_char_ff),
      .state_cur (state_ff),
      .acc_cur   (acc_ff),
      .state_nxt (state_nxt),
      .acc_nxt   (acc_nxt),
      .res_valid (res_valid),
      .res_value (res_value)
   );

   assign advance = !out_valid_ff || !rsp_stall;
   assign s1_load = !s1_valid_ff || advance;
   assign req_stall = !s1_load;
   assign fire = s1_valid_ff && advance;

   always_comb begin
      s1_valid_in = s1_load ? req_valid : s1_valid_ff;
      out_valid_in = advance ? (s1_valid_ff && s1_last_ff) : out_valid_ff;
      state_in = state_ff;
      acc_in = acc_ff;
      if (fire) begin
         // state restarts after every literal
         state_in = s1_last_ff ? STATE_RESET : state_nxt;
         acc_in = s1_last_ff ? '0 : acc_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= STATE_RESET;
         acc_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_last_char;
      end
      if (fire && s1_last_ff) begin
         out_is_valid_ff <= res_valid;
         out_value_ff <= res_value;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_is_valid = out_is_valid_ff;
   assign rsp_result_value = out_value_ff;

endmodule
`default_nettype wire
